// ===== rtl/tsc_pkg.sv =====
// ----------------------------------------------------------------------------
// tsc_pkg
// shared types and constants for triangle setup and culling
// ----------------------------------------------------------------------------
package tsc_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COORD_W       = 32;
    localparam int SIZE_W        = 13;
    localparam int QUO_BITS      = 33;
    // product stage, setup stage, one stage per quotient bit, saturation stage
    localparam int LANE_LAT      = QUO_BITS + 3;
    localparam int NUM_LANES     = 6;

    typedef enum logic [1:0] {
        OUT_DRAWN   = 2'd0,
        OUT_ZERO_W  = 2'd1,
        OUT_DEPTH   = 2'd2,
        OUT_CULLED  = 2'd3
    } outcome_t;

    typedef enum logic [1:0] {
        CULL_NONE   = 2'd0,
        CULL_FRONT  = 2'd1,
        CULL_BACK   = 2'd2,
        CULL_UNUSED = 2'd3
    } cull_t;

    typedef enum logic [1:0] {
        REG_WIDTH   = 2'd0,
        REG_HEIGHT  = 2'd1,
        REG_WINDING = 2'd2,
        REG_CULL    = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic  winding_front;
        cull_t cull_select;
    } cull_cfg_t;

endpackage

// ===== rtl/tsc_lane.sv =====
// ----------------------------------------------------------------------------
// tsc_lane
// one screen coordinate: scale by viewport size, pipelined divide by w, saturate
// ----------------------------------------------------------------------------
module tsc_lane #(
    parameter int FRAC_BITS = tsc_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [tsc_pkg::COORD_W:0]    sum,
    input  logic [tsc_pkg::SIZE_W-1:0]          scale,
    input  logic signed [tsc_pkg::COORD_W-1:0]  den,
    output logic signed [tsc_pkg::COORD_W-1:0]  result
);

    localparam int QB = tsc_pkg::QUO_BITS;
    localparam int PW = tsc_pkg::COORD_W + 1 + tsc_pkg::SIZE_W;
    localparam int NW = PW + FRAC_BITS - 1;
    localparam int HW = NW - QB;
    localparam int CW = (HW > 32) ? HW : 32;

    logic [PW-1:0] prod_reg;
    logic          neg0_reg;
    logic [31:0]   d0_reg;
    logic [32:0]   sum_mag;
    logic [31:0]   den_mag;

    logic [NW-1:0] n_full;
    logic [HW-1:0] n_hi;
    logic          ovf_now;

    logic [31:0]   rem_reg [QB+1];
    logic [QB-1:0] lo_reg  [QB+1];
    logic [31:0]   d_reg   [QB+1];
    logic          neg_reg [QB+1];
    logic          ovf_reg [QB+1];

    logic signed [31:0] result_reg;
    logic signed [31:0] result_next;

    assign sum_mag = sum[32] ? 33'(-sum) : 33'(sum);
    assign den_mag = den[31] ? 32'(-den) : 32'(den);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PW'(sum_mag) * PW'(scale);
            neg0_reg <= sum[32] ^ den[31];
            d0_reg   <= den_mag;
        end
    end

    assign n_full  = {prod_reg, {(FRAC_BITS-1){1'b0}}};
    assign n_hi    = n_full[NW-1:QB];
    assign ovf_now = CW'(n_hi) >= CW'(d0_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= 32'(n_hi);
            lo_reg[0]  <= n_full[QB-1:0];
            d_reg[0]   <= d0_reg;
            neg_reg[0] <= neg0_reg;
            ovf_reg[0] <= ovf_now;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar s = 1; s <= QB; s++)
    begin : g_step
        logic [32:0] trial;
        logic [33:0] diff;
        logic        ge;

        assign trial = {rem_reg[s-1], lo_reg[s-1][QB-1]};
        assign diff  = {1'b0, trial} - {2'b00, d_reg[s-1]};
        assign ge    = ~diff[33];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= ge ? diff[31:0] : trial[31:0];
                lo_reg[s]  <= {lo_reg[s-1][QB-2:0], ge};
                d_reg[s]   <= d_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
                ovf_reg[s] <= ovf_reg[s-1];
            end
        end
    end

    always_comb
    begin
        if (!neg_reg[QB])
        begin
            if (ovf_reg[QB] || lo_reg[QB] > 33'h07FFFFFFF)
                result_next = 32'sh7FFFFFFF;
            else
                result_next = signed'(lo_reg[QB][31:0]);
        end
        else
        begin
            if (ovf_reg[QB] || lo_reg[QB] >= 33'h080000000)
                result_next = 32'sh80000000;
            else
                result_next = signed'(32'(-lo_reg[QB][31:0]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

// ===== rtl/tsc_merge.sv =====
// ----------------------------------------------------------------------------
// tsc_merge
// combines lane results: signed area, cull decision and result register
// ----------------------------------------------------------------------------
module tsc_merge (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_vld,
    input  tsc_pkg::outcome_t                  in_stat,
    input  logic signed [tsc_pkg::COORD_W-1:0] scr [tsc_pkg::NUM_LANES],
    input  tsc_pkg::cull_cfg_t                 cfg,
    output logic                               out_vld,
    output tsc_pkg::outcome_t                  outcome,
    output logic signed [tsc_pkg::COORD_W-1:0] o_scr [tsc_pkg::NUM_LANES]
);

    localparam int N = tsc_pkg::NUM_LANES;

    logic                 vld1_reg;
    tsc_pkg::outcome_t    stat1_reg;
    logic signed [31:0]   scr1_reg [N];
    logic signed [65:0]   p_reg;
    logic signed [65:0]   q_reg;
    logic signed [32:0]   e_bx, e_cy, e_by, e_cx;

    logic                 vld_reg;
    tsc_pkg::outcome_t    outcome_reg;
    tsc_pkg::outcome_t    outcome_next;
    logic signed [31:0]   scr_reg [N];
    logic                 pos, neg, cull;

    assign e_bx = 33'(scr[2]) - 33'(scr[0]);
    assign e_cy = 33'(scr[5]) - 33'(scr[1]);
    assign e_by = 33'(scr[3]) - 33'(scr[1]);
    assign e_cx = 33'(scr[4]) - 33'(scr[0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld1_reg <= 1'b0;
        else if (en)
            vld1_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stat1_reg <= in_stat;
            scr1_reg  <= scr;
            p_reg     <= 66'(e_bx) * 66'(e_cy);
            q_reg     <= 66'(e_by) * 66'(e_cx);
        end
    end

    assign pos = p_reg > q_reg;
    assign neg = p_reg < q_reg;

    always_comb
    begin
        unique case (cfg.cull_select)
            tsc_pkg::CULL_FRONT:  cull = cfg.winding_front ? neg : pos;
            tsc_pkg::CULL_BACK:   cull = cfg.winding_front ? pos : neg;
            tsc_pkg::CULL_NONE,
            tsc_pkg::CULL_UNUSED: cull = 1'b0;
            default:              cull = 1'b0;
        endcase
        if (stat1_reg != tsc_pkg::OUT_DRAWN)
            outcome_next = stat1_reg;
        else if (cull)
            outcome_next = tsc_pkg::OUT_CULLED;
        else
            outcome_next = tsc_pkg::OUT_DRAWN;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            outcome_reg <= outcome_next;
            for (int k = 0; k < N; k++)
                scr_reg[k] <= (stat1_reg == tsc_pkg::OUT_ZERO_W ||
                               stat1_reg == tsc_pkg::OUT_DEPTH) ? 32'sd0 : scr1_reg[k];
        end
    end

    assign out_vld = vld_reg;
    assign outcome = outcome_reg;
    assign o_scr   = scr_reg;

endmodule

// ===== rtl/triangle_setup_cull.sv =====
// ----------------------------------------------------------------------------
// triangle_setup_cull
// perspective divide, viewport mapping and face culling for triangles
// ----------------------------------------------------------------------------
// one triangle (three clip-space vertices) is taken per input transfer, and
// one result (outcome plus three screen points) leaves per output transfer.
// six lanes, one per screen coordinate, each run a 33-stage pipelined
// divider; the merge block forms the signed area and decides culling.
// throughput: one triangle per cycle while the output is not stalled. the path
// from input transfer to output valid is 36 lane stages plus two merge stages.
// the whole pipeline advances when the output register is empty or being
// taken; in_ready follows that, so a stalled receiver holds every stage and
// back-pressure reaches the input in the same cycle.
// configuration writes are taken every cycle (cfg_ready is tied high) and
// should only be issued while no triangle is in flight.
// reset clears all valid flags and loads width 640, height 480,
// counter-clockwise front faces and back-face culling.
// ----------------------------------------------------------------------------
module triangle_setup_cull #(
    parameter int FRAC_BITS = tsc_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [12:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic signed [31:0] a_z,
    input  logic signed [31:0] a_w,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic signed [31:0] b_z,
    input  logic signed [31:0] b_w,
    input  logic signed [31:0] c_x,
    input  logic signed [31:0] c_y,
    input  logic signed [31:0] c_z,
    input  logic signed [31:0] c_w,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         outcome,
    output logic signed [31:0] sa_x,
    output logic signed [31:0] sa_y,
    output logic signed [31:0] sb_x,
    output logic signed [31:0] sb_y,
    output logic signed [31:0] sc_x,
    output logic signed [31:0] sc_y
);

    localparam int LAT = tsc_pkg::LANE_LAT;
    localparam int N   = tsc_pkg::NUM_LANES;

    logic [12:0]          width_reg;
    logic [12:0]          height_reg;
    tsc_pkg::cull_cfg_t   cfg_reg;

    logic                 en;
    logic                 vld_reg  [LAT];
    tsc_pkg::outcome_t    stat_reg [LAT];
    tsc_pkg::outcome_t    stat_in;

    logic signed [31:0]   vx [3];
    logic signed [31:0]   vy [3];
    logic signed [31:0]   vz [3];
    logic signed [31:0]   vw [3];
    logic signed [31:0]   scr   [N];
    logic signed [31:0]   o_scr [N];
    tsc_pkg::outcome_t    outcome_w;
    logic                 out_vld;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg             <= 13'd640;
            height_reg            <= 13'd480;
            cfg_reg.winding_front <= 1'b0;
            cfg_reg.cull_select   <= tsc_pkg::CULL_BACK;
        end
        else if (cfg_valid)
        begin
            unique case (tsc_pkg::reg_idx_t'(cfg_index))
                tsc_pkg::REG_WIDTH:   width_reg             <= cfg_data;
                tsc_pkg::REG_HEIGHT:  height_reg            <= cfg_data;
                tsc_pkg::REG_WINDING: cfg_reg.winding_front <= cfg_data[0];
                tsc_pkg::REG_CULL:    cfg_reg.cull_select   <= tsc_pkg::cull_t'(cfg_data[1:0]);
                default:              width_reg             <= width_reg;
            endcase
        end
    end

    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    assign vx = '{a_x, b_x, c_x};
    assign vy = '{a_y, b_y, c_y};
    assign vz = '{a_z, b_z, c_z};
    assign vw = '{a_w, b_w, c_w};

    // first failing vertex decides the rejection code
    always_comb
    begin
        logic [32:0] zm, wm;
        stat_in = tsc_pkg::OUT_DRAWN;
        for (int v = 2; v >= 0; v--)
        begin
            zm = vz[v][31] ? 33'(-33'(vz[v])) : 33'(vz[v]);
            wm = vw[v][31] ? 33'(-33'(vw[v])) : 33'(vw[v]);
            if (vw[v] == 32'sd0)
                stat_in = tsc_pkg::OUT_ZERO_W;
            else if (zm > wm)
                stat_in = tsc_pkg::OUT_DEPTH;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < LAT; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stat_reg[0] <= stat_in;
            for (int k = 1; k < LAT; k++)
                stat_reg[k] <= stat_reg[k-1];
        end
    end

    for (genvar v = 0; v < 3; v++)
    begin : g_vtx
        tsc_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
            .clk    (clk),
            .en     (en),
            .sum    (33'(vx[v]) + 33'(vw[v])),
            .scale  (width_reg),
            .den    (vw[v]),
            .result (scr[2*v])
        );
        tsc_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
            .clk    (clk),
            .en     (en),
            .sum    (33'(vw[v]) - 33'(vy[v])),
            .scale  (height_reg),
            .den    (vw[v]),
            .result (scr[2*v+1])
        );
    end

    tsc_merge u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (vld_reg[LAT-1]),
        .in_stat (stat_reg[LAT-1]),
        .scr     (scr),
        .cfg     (cfg_reg),
        .out_vld (out_vld),
        .outcome (outcome_w),
        .o_scr   (o_scr)
    );

    assign out_valid = out_vld;
    assign outcome   = outcome_w;
    assign sa_x      = o_scr[0];
    assign sa_y      = o_scr[1];
    assign sb_x      = o_scr[2];
    assign sb_y      = o_scr[3];
    assign sc_x      = o_scr[4];
    assign sc_y      = o_scr[5];

endmodule
